### rtl/p2v_pkg.sv
// Package: shared constants and register map for the point-to-voxel block.
package p2v_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int GRID_BITS_DEF  = 11;
  localparam int FRAC_BITS      = 10;
  localparam int CFG_IDX_W      = 3;

  // Voxel edge length of 1.0 in the fixed-point scale.
  localparam int STEP_RESET = 1 << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_ORIGIN_Z  = 3'd2,
    REG_STEP_X    = 3'd3,
    REG_STEP_Y    = 3'd4,
    REG_STEP_Z    = 3'd5,
    REG_GRID_DIMS = 3'd6
  } cfg_reg_t;

endpackage

### rtl/p2v_axis_div.sv
// One axis: origin subtract, range check and pipelined restoring divide.
module p2v_axis_div import p2v_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int GRID_BITS  = GRID_BITS_DEF
) (
  input  logic                  clk,
  input  logic [GRID_BITS+1:0]  adv,
  input  logic [COORD_BITS-1:0] pt,
  input  logic [COORD_BITS-1:0] org,
  input  logic [COORD_BITS-2:0] step,
  output logic [GRID_BITS-1:0]  q,
  output logic                  ok
);

  localparam int DSTG = GRID_BITS + 2;
  localparam int W    = COORD_BITS + GRID_BITS;

  logic [W-1:0]         rem_r [DSTG-1];
  logic [GRID_BITS-1:0] q_r   [DSTG];
  logic                 ok_r  [DSTG];
  logic [COORD_BITS:0]  diff;

  // Sign-extended difference; the top bit flags a point below the origin.
  assign diff = {pt[COORD_BITS-1], pt} - {org[COORD_BITS-1], org};

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      rem_r[0] <= W'(diff[COORD_BITS-1:0]);
      ok_r[0]  <= !diff[COORD_BITS] && (step != '0);
      q_r[0]   <= '0;
    end
  end

  // Quotient at or above 2^GRID_BITS is outside every grid size.
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      rem_r[1] <= rem_r[0];
      ok_r[1]  <= ok_r[0] && (rem_r[0] < (W'(step) << GRID_BITS));
      q_r[1]   <= q_r[0];
    end
  end

  for (genvar s = 2; s < DSTG; s++) begin : g_div
    localparam int K = DSTG - 1 - s;
    logic [W-1:0]         dvs;
    logic                 ge;
    logic [GRID_BITS-1:0] q_nxt;

    always_comb begin
      dvs      = W'(step) << K;
      ge       = rem_r[s-1] >= dvs;
      q_nxt    = q_r[s-1];
      q_nxt[K] = ge;
    end

    always_ff @(posedge clk) begin
      if (adv[s]) begin
        q_r[s]  <= q_nxt;
        ok_r[s] <= ok_r[s-1];
      end
    end

    if (s < DSTG - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv[s]) begin
          rem_r[s] <= ge ? rem_r[s-1] - dvs : rem_r[s-1];
        end
      end
    end else begin : g_tail
      // Final remainder is not needed.
    end
  end

  assign q  = q_r[DSTG-1];
  assign ok = ok_r[DSTG-1];

endmodule

### rtl/point_to_voxel_coordinate.sv
// Top level: point to voxel grid coordinate, fully pipelined, one point per cycle unless stalled.
//
//   channel | signals                                    | transaction
//   --------+--------------------------------------------+----------------------------
//   in      | in_valid/in_ready, point_x/y/z, last_point | one point
//   out     | out_valid/out_ready, voxel_z/y/x,          | one voxel coordinate
//           | inside_res, last_out                       |
//   cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data   | one register write
//
// Pipeline: one point per cycle sustained while out_ready is high; stages are
//   the input subtract stage, overflow check, one stage per quotient bit of
//   the restoring divider, then the grid-size compare in the output register.
// Reset: rst_n synchronous, active low; clears valid bits and the config
//   registers (origins 0, steps 1.0, grid dims 0).
// Stalls: each stage has its own valid bit and holds while the stage after
//   it is full and stalled; bubbles collapse, so the input keeps taking
//   points until every stage is full.
module point_to_voxel_coordinate import p2v_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int GRID_BITS  = GRID_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic signed [COORD_BITS-1:0] in_point_z,
  input  logic                         in_last_point,

  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [GRID_BITS:0]    out_voxel_z,
  output logic signed [GRID_BITS:0]    out_voxel_y,
  output logic signed [GRID_BITS:0]    out_voxel_x,
  output logic                         out_inside_res,
  output logic                         out_last_out,

  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [(COORD_BITS > 3*GRID_BITS ? COORD_BITS : 3*GRID_BITS)-1:0] cfg_data
);

  localparam int DSTG = GRID_BITS + 2;  // stages inside each axis divider
  localparam int NSTG = DSTG + 1;       // plus the output register

  // ---------------------------------------------------------------- config
  logic [COORD_BITS-1:0]  origin_x_r, origin_y_r, origin_z_r;
  logic [COORD_BITS-2:0]  step_x_r, step_y_r, step_z_r;
  logic [3*GRID_BITS-1:0] grid_dims_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r  <= '0;
      origin_y_r  <= '0;
      origin_z_r  <= '0;
      step_x_r    <= (COORD_BITS-1)'(STEP_RESET);
      step_y_r    <= (COORD_BITS-1)'(STEP_RESET);
      step_z_r    <= (COORD_BITS-1)'(STEP_RESET);
      grid_dims_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORIGIN_X:  origin_x_r  <= cfg_data[COORD_BITS-1:0];
        REG_ORIGIN_Y:  origin_y_r  <= cfg_data[COORD_BITS-1:0];
        REG_ORIGIN_Z:  origin_z_r  <= cfg_data[COORD_BITS-1:0];
        REG_STEP_X:    step_x_r    <= cfg_data[COORD_BITS-2:0];
        REG_STEP_Y:    step_y_r    <= cfg_data[COORD_BITS-2:0];
        REG_STEP_Z:    step_z_r    <= cfg_data[COORD_BITS-2:0];
        REG_GRID_DIMS: grid_dims_r <= cfg_data[3*GRID_BITS-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // --------------------------------------------------------- pipe control
  // rdy[i]: stage i can take new data this cycle. ld[i]: it does.
  logic [NSTG-1:0] valid_r;
  logic [NSTG:0]   rdy;
  logic [NSTG-1:0] ld;
  logic [NSTG-1:0] last_r;

  assign rdy[NSTG] = out_ready;
  for (genvar i = 0; i < NSTG; i++) begin : g_ctl
    assign rdy[i] = !valid_r[i] || rdy[i+1];
    if (i == 0) begin : g_head
      assign ld[i] = rdy[i] && in_valid;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[i] <= 1'b0;
        end else if (rdy[i]) begin
          valid_r[i] <= in_valid;
        end
      end
      always_ff @(posedge clk) begin
        if (ld[i]) begin
          last_r[i] <= in_last_point;
        end
      end
    end else begin : g_body
      assign ld[i] = rdy[i] && valid_r[i-1];
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[i] <= 1'b0;
        end else if (rdy[i]) begin
          valid_r[i] <= valid_r[i-1];
        end
      end
      always_ff @(posedge clk) begin
        if (ld[i]) begin
          last_r[i] <= last_r[i-1];
        end
      end
    end
  end

  assign in_ready = rdy[0];

  // ------------------------------------------------------------ axis units
  logic [GRID_BITS-1:0] qx, qy, qz;
  logic                 okx, oky, okz;

  p2v_axis_div #(.COORD_BITS(COORD_BITS), .GRID_BITS(GRID_BITS)) u_div_x (
    .clk (clk), .adv (ld[DSTG-1:0]), .pt (in_point_x), .org (origin_x_r),
    .step (step_x_r), .q (qx), .ok (okx)
  );
  p2v_axis_div #(.COORD_BITS(COORD_BITS), .GRID_BITS(GRID_BITS)) u_div_y (
    .clk (clk), .adv (ld[DSTG-1:0]), .pt (in_point_y), .org (origin_y_r),
    .step (step_y_r), .q (qy), .ok (oky)
  );
  p2v_axis_div #(.COORD_BITS(COORD_BITS), .GRID_BITS(GRID_BITS)) u_div_z (
    .clk (clk), .adv (ld[DSTG-1:0]), .pt (in_point_z), .org (origin_z_r),
    .step (step_z_r), .q (qz), .ok (okz)
  );

  // ---------------------------------------------------- grid check / output
  logic                 hit_all;
  logic [GRID_BITS:0]   vox_x_r, vox_y_r, vox_z_r;
  logic                 inside_r;

  assign hit_all = okx && (qx < grid_dims_r[GRID_BITS-1:0])
                && oky && (qy < grid_dims_r[2*GRID_BITS-1:GRID_BITS])
                && okz && (qz < grid_dims_r[3*GRID_BITS-1:2*GRID_BITS]);

  // Any axis out of range forces all three indices to -1.
  always_ff @(posedge clk) begin
    if (ld[NSTG-1]) begin
      vox_x_r  <= hit_all ? {1'b0, qx} : '1;
      vox_y_r  <= hit_all ? {1'b0, qy} : '1;
      vox_z_r  <= hit_all ? {1'b0, qz} : '1;
      inside_r <= hit_all;
    end
  end

  assign out_valid      = valid_r[NSTG-1];
  assign out_voxel_x    = vox_x_r;
  assign out_voxel_y    = vox_y_r;
  assign out_voxel_z    = vox_z_r;
  assign out_inside_res = inside_r;
  assign out_last_out   = last_r[NSTG-1];

  // ------------------------------------------------------------ assertions
  a_accept_fills_head: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> valid_r[0])
    else $error("accepted point did not enter the first stage");

  a_mid_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[NSTG-2] && !rdy[NSTG-1] |=> valid_r[NSTG-2])
    else $error("stalled divider stage lost its point");

  a_inside_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inside_res |->
      !out_voxel_x[GRID_BITS] && !out_voxel_y[GRID_BITS] && !out_voxel_z[GRID_BITS])
    else $error("inside result carries a negative index");

  a_outside_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_inside_res |->
      (vox_x_r == '1) && (vox_y_r == '1) && (vox_z_r == '1))
    else $error("outside result is not -1 on every axis");

endmodule

### tb/tb_top.sv
// Testbench for point_to_voxel_coordinate: predicted voxel coordinates checked per transaction.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import p2v_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int GB = GRID_BITS_DEF;
  localparam int DW = (CB > 3*GB) ? CB : 3*GB;

  // Index past the end of the register map; the block must drop such writes.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam longint COORD_MIN = -(longint'(1) << (CB-1));
  localparam longint COORD_MAX = (longint'(1) << (CB-1)) - 1;
  localparam longint STEP_MAX  = (longint'(1) << (CB-1)) - 1;
  localparam longint DIM_MAX   = (longint'(1) << GB) - 1;
  localparam longint ONE       = longint'(STEP_RESET);  // 1.0 in fixed point

  // Packed records the testbench carries around; coordinates and indices are two's complement.
  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
    logic                 last;
  } point_t;

  typedef struct packed {
    logic signed [GB:0] vz;
    logic signed [GB:0] vy;
    logic signed [GB:0] vx;
    logic               hit;
    logic               last;
  } voxel_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] idx;
    logic [DW-1:0]        data;
  } reg_write_t;

  // Receiver back-pressure styles.
  typedef enum int { RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_LONG } rx_mode_t;

  // Where a generated coordinate falls relative to its axis range.
  typedef enum int { PT_INSIDE, PT_EDGE_HIGH, PT_EDGE_LOW, PT_ANY } coord_kind_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  logic                 in_ready;
  logic signed [CB-1:0] in_point_x    = '0;
  logic signed [CB-1:0] in_point_y    = '0;
  logic signed [CB-1:0] in_point_z    = '0;
  logic                 in_last_point = 1'b0;
  logic                 out_valid;
  logic                 out_ready     = 1'b0;
  logic signed [GB:0]   out_voxel_z;
  logic signed [GB:0]   out_voxel_y;
  logic signed [GB:0]   out_voxel_x;
  logic                 out_inside_res;
  logic                 out_last_out;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [DW-1:0]        cfg_data      = '0;

  always #4 clk = ~clk;

  point_to_voxel_coordinate #(
    .COORD_BITS (CB),
    .GRID_BITS  (GB)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_point_z     (in_point_z),
    .in_last_point  (in_last_point),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_voxel_z    (out_voxel_z),
    .out_voxel_y    (out_voxel_y),
    .out_voxel_x    (out_voxel_x),
    .out_inside_res (out_inside_res),
    .out_last_out   (out_last_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the register file, axis 0 = x, 1 = y, 2 = z.
  // ---------------------------------------------------------------------------
  logic signed [CB-1:0] grid_origin [3];
  logic [CB-2:0]        voxel_step  [3];
  logic [3*GB-1:0]      grid_dims;

  voxel_t     pending_voxels [$];   // predicted coordinates, oldest first
  reg_write_t reg_writes     [$];   // register transactions waiting to go out

  int       n_points     = 0;
  int       n_results    = 0;
  int       n_mismatch   = 0;
  int       n_reg_writes = 0;
  int       n_settings   = 0;
  int       burst_left   = 0;
  int       gap_max      = 0;
  rx_mode_t rx_mode      = RX_ALWAYS;
  int       rx_tick      = 0;
  int       rx_hold      = 0;
  logic     rx_level     = 1'b1;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [GB-1:0] dim_of(input int axis);
    return grid_dims[axis*GB +: GB];
  endfunction

  // Floor index along one axis; returns 0 when the point misses the axis.
  function automatic bit axis_hit(input int axis, input logic signed [CB-1:0] pt,
                                  output logic [GB-1:0] idx);
    longint diff;
    longint q;
    diff = longint'(pt) - longint'(grid_origin[axis]);
    idx  = '0;
    if (voxel_step[axis] == '0 || diff < 0) return 1'b0;
    q = diff / longint'(voxel_step[axis]);
    if (q >= longint'(dim_of(axis))) return 1'b0;
    idx = q[GB-1:0];
    return 1'b1;
  endfunction

  function automatic voxel_t voxel_of_point(input point_t p);
    voxel_t        v;
    logic [GB-1:0] ix, iy, iz;
    bit            hx, hy, hz;
    hx = axis_hit(0, p.x, ix);
    hy = axis_hit(1, p.y, iy);
    hz = axis_hit(2, p.z, iz);
    v.last = p.last;
    if (hx && hy && hz) begin
      v.vz  = {1'b0, iz};
      v.vy  = {1'b0, iy};
      v.vx  = {1'b0, ix};
      v.hit = 1'b1;
    end else begin
      // one missed axis knocks out all three indices
      v.vz  = '1;
      v.vy  = '1;
      v.vx  = '1;
      v.hit = 1'b0;
    end
    return v;
  endfunction

  function automatic point_t mk_point(input longint x, input longint y, input longint z,
                                      input bit last);
    point_t p;
    p.x    = x[CB-1:0];
    p.y    = y[CB-1:0];
    p.z    = z[CB-1:0];
    p.last = last;
    return p;
  endfunction

  // Coordinate on one axis of the current grid; falls back to a fully random
  // value when the target cannot be represented in CB bits.
  function automatic logic signed [CB-1:0] axis_coord(input int axis, input coord_kind_t kind);
    longint      c;
    longint      org, st, sz;
    logic [31:0] r;
    org = longint'(grid_origin[axis]);
    st  = longint'(voxel_step[axis]);
    sz  = longint'(dim_of(axis));
    c   = COORD_MAX + 1;
    case (kind)
      PT_INSIDE: begin
        if (st != 0 && sz != 0)
          c = org + longint'($urandom_range(0, 32'(sz - 1))) * st + longint'($urandom >> 1) % st;
      end
      PT_EDGE_HIGH: begin
        // last voxel's top edge or first step past the grid
        if (st != 0) c = org + sz * st - 1 + longint'($urandom_range(0, 1));
      end
      PT_EDGE_LOW: begin
        // just below the origin or exactly on it
        c = org - 1 + longint'($urandom_range(0, 1));
      end
      default: ;
    endcase
    if (c < COORD_MIN || c > COORD_MAX) begin
      r = $urandom;
      return r[CB-1:0];
    end
    return c[CB-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  task automatic send_point(input point_t p);
    int gap;
    if (burst_left == 0) begin
      gap        = (gap_max == 0) ? 0 : int'($urandom_range(0, gap_max));
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_point_x    <= p.x;
    in_point_y    <= p.y;
    in_point_z    <= p.z;
    in_last_point <= p.last;
    do @(posedge clk); while (in_ready !== 1'b1);
    // config is frozen while points are in flight, so predict at acceptance
    pending_voxels.push_back(voxel_of_point(p));
    n_points++;
  endtask

  // Stop sending and wait for every predicted transaction to come back.
  task automatic drain;
    in_valid   <= 1'b0;
    burst_left = 0;
    while (pending_voxels.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------
  function automatic void queue_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DW-1:0] data);
    reg_write_t w;
    w.idx  = idx;
    w.data = data;
    reg_writes.push_back(w);
  endfunction

  // Back-to-back register transactions; valid drops once after the last one.
  task automatic flush_regs;
    reg_write_t w;
    while (reg_writes.size() != 0) begin
      w = reg_writes.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= w.idx;
      cfg_data  <= w.data;
      do @(posedge clk); while (cfg_ready !== 1'b1);
      case (w.idx)
        REG_ORIGIN_X:  grid_origin[0] = w.data[CB-1:0];
        REG_ORIGIN_Y:  grid_origin[1] = w.data[CB-1:0];
        REG_ORIGIN_Z:  grid_origin[2] = w.data[CB-1:0];
        REG_STEP_X:    voxel_step[0]  = w.data[CB-2:0];
        REG_STEP_Y:    voxel_step[1]  = w.data[CB-2:0];
        REG_STEP_Z:    voxel_step[2]  = w.data[CB-2:0];
        REG_GRID_DIMS: grid_dims      = w.data[3*GB-1:0];
        default: ;  // unmapped index: dropped
      endcase
      n_reg_writes++;
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: back-pressure pattern and result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : rx_stall
    case (rx_mode)
      RX_ALWAYS:  out_ready <= 1'b1;
      RX_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
      RX_PATTERN: begin
        // a repeating pattern: a run of ready, then a shorter run of stalled
        rx_tick   = (rx_tick + 1) % 7;
        out_ready <= (rx_tick < 4);
      end
      default: begin
        // long alternating runs of ready and stall
        if (rx_hold == 0) begin
          rx_level = ~rx_level;
          rx_hold  = rx_level ? $urandom_range(1, 12) : $urandom_range(1, 24);
        end else begin
          rx_hold--;
        end
        out_ready <= rx_level;
      end
    endcase
  end

  always @(posedge clk) begin : check_voxels
    voxel_t got;
    voxel_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      got.vz   = out_voxel_z;
      got.vy   = out_voxel_y;
      got.vx   = out_voxel_x;
      got.hit  = out_inside_res;
      got.last = out_last_out;
      n_results++;
      if (pending_voxels.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("[%0t] unexpected voxel transaction: z=%0d y=%0d x=%0d in=%0b last=%0b",
                   $realtime, got.vz, got.vy, got.vx, got.hit, got.last);
      end else begin
        want = pending_voxels.pop_front();
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display({"[%0t] voxel mismatch: expected z=%0d y=%0d x=%0d in=%0b last=%0b",
                      " got z=%0d y=%0d x=%0d in=%0b last=%0b"},
                     $realtime, want.vz, want.vy, want.vx, want.hit, want.last,
                     got.vz, got.vy, got.vx, got.hit, got.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Grid dims reset to zero, so every point lands outside.
  task automatic test_reset_state;
    send_point(mk_point(0, 0, 0, 1'b1));
    send_point(mk_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0));
    send_point(mk_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1));
    drain();
  endtask

  // Default steps of 1.0 with a full grid, then distinct dims to pin the packing.
  task automatic test_unit_grid;
    queue_reg(REG_GRID_DIMS, DW'({3*GB{1'b1}}));
    flush_regs();
    send_point(mk_point(0, 0, 0, 1'b0));
    send_point(mk_point(5*ONE, 7*ONE, 9*ONE, 1'b1));            // z, y, x ordering
    send_point(mk_point(DIM_MAX*ONE-1, DIM_MAX*ONE-1, DIM_MAX*ONE-1, 1'b0));
    send_point(mk_point(DIM_MAX*ONE, 0, 0, 1'b0));              // x one past the top
    send_point(mk_point(0, -1, 0, 1'b1));                       // y just below origin
    send_point(mk_point(0, 0, DIM_MAX*ONE, 1'b0));              // z one past the top
    drain();
    queue_reg(REG_GRID_DIMS, DW'({GB'(7), GB'(5), GB'(3)}));
    flush_regs();
    send_point(mk_point(2*ONE, 4*ONE, 6*ONE, 1'b0));
    send_point(mk_point(3*ONE, 0, 0, 1'b0));
    send_point(mk_point(0, 5*ONE, 0, 1'b1));
    send_point(mk_point(0, 0, 7*ONE, 1'b0));
    drain();
  endtask

  // Extreme origins and steps against extreme coordinates.
  task automatic test_extremes;
    for (int a = 0; a < 3; a++) begin
      queue_reg(CFG_IDX_W'(int'(REG_ORIGIN_X) + a), DW'(COORD_MIN));
      queue_reg(CFG_IDX_W'(int'(REG_STEP_X) + a), DW'(STEP_MAX));
    end
    queue_reg(REG_GRID_DIMS, DW'({3*GB{1'b1}}));
    flush_regs();
    send_point(mk_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
    send_point(mk_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0));
    drain();
    for (int a = 0; a < 3; a++) queue_reg(CFG_IDX_W'(int'(REG_STEP_X) + a), DW'(1));
    flush_regs();
    send_point(mk_point(COORD_MIN + DIM_MAX - 1, COORD_MIN, COORD_MIN + DIM_MAX, 1'b0));
    drain();
    for (int a = 0; a < 3; a++) queue_reg(CFG_IDX_W'(int'(REG_ORIGIN_X) + a), DW'(COORD_MAX));
    flush_regs();
    send_point(mk_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0));
    send_point(mk_point(COORD_MAX - 1, COORD_MAX, COORD_MAX, 1'b1));
    drain();
  endtask

  // Masking of stray register bits, zero step, unmapped index, zero grid size.
  task automatic test_special_cases;
    queue_reg(REG_ORIGIN_X, 33'h1_FF00_0400);   // junk above bit 23, origin 1.0
    queue_reg(REG_ORIGIN_Y, '0);
    queue_reg(REG_ORIGIN_Z, '0);
    queue_reg(REG_STEP_X, 33'h1_FF80_0800);     // junk from bit 23 up, step 2.0
    queue_reg(REG_STEP_Y, DW'(ONE));
    queue_reg(REG_STEP_Z, DW'(ONE));
    flush_regs();
    send_point(mk_point(ONE + 3*2*ONE, 0, 0, 1'b0));
    drain();
    queue_reg(REG_STEP_Y, '0);
    flush_regs();
    send_point(mk_point(ONE, 0, 0, 1'b1));      // y has no step: outside
    drain();
    queue_reg(REG_UNUSED, DW'(ONE));            // must not revive step_y
    flush_regs();
    send_point(mk_point(ONE, 0, 0, 1'b0));
    drain();
    queue_reg(REG_STEP_Y, DW'(ONE));
    queue_reg(REG_GRID_DIMS, DW'({GB'(0), {GB{1'b1}}, {GB{1'b1}}}));
    flush_regs();
    send_point(mk_point(ONE, 0, 0, 1'b0));      // z has no voxels: outside
    drain();
  endtask

  // Fresh random register set for one phase; random junk rides above each origin and step field.
  task automatic randomize_regs;
    logic [63:0]   r;
    logic [DW-1:0] d;
    longint        v;
    logic [GB-1:0] dims [3];
    for (int a = 0; a < 3; a++) begin
      case ($urandom_range(0, 7))
        0:       v = 0;
        1:       v = COORD_MIN;
        2:       v = COORD_MAX;
        3, 4:    v = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
        default: v = longint'($urandom >> 1);
      endcase
      r = {$urandom, $urandom};
      d = r[DW-1:0];
      d[CB-1:0] = v[CB-1:0];
      queue_reg(CFG_IDX_W'(int'(REG_ORIGIN_X) + a), d);
      case ($urandom_range(0, 15))
        0:       v = 1;
        1:       v = STEP_MAX;
        2:       v = ONE;
        3:       v = 0;
        4:       v = longint'($urandom >> 1);
        default: v = longint'($urandom_range(1, 4096));
      endcase
      r = {$urandom, $urandom};
      d = r[DW-1:0];
      d[CB-2:0] = v[CB-2:0];
      queue_reg(CFG_IDX_W'(int'(REG_STEP_X) + a), d);
      case ($urandom_range(0, 9))
        0:       dims[a] = '0;
        1:       dims[a] = GB'(1);
        2:       dims[a] = '1;
        3:       dims[a] = GB'($urandom_range(1, 16));
        default: dims[a] = GB'($urandom_range(1, 32'(DIM_MAX)));
      endcase
    end
    queue_reg(REG_GRID_DIMS, DW'({dims[2], dims[1], dims[0]}));
    if ($urandom_range(0, 3) == 0) begin
      r = {$urandom, $urandom};
      queue_reg(REG_UNUSED, r[DW-1:0]);
    end
    flush_regs();
  endtask

  // Mostly points that land in the grid, some on its edges, some anywhere.
  task automatic test_random_phases(input int n_phases, input int per_phase);
    coord_kind_t kind [3];
    point_t      p;
    int          sel;
    for (int ph = 0; ph < n_phases; ph++) begin
      drain();
      if (ph == 0) begin
        gap_max = 0;
        rx_mode = RX_ALWAYS;
      end else begin
        gap_max = $urandom_range(1, 8);
        rx_mode = rx_mode_t'(ph % 4);
      end
      randomize_regs();
      for (int i = 0; i < per_phase; i++) begin
        sel = $urandom_range(0, 9);
        for (int a = 0; a < 3; a++) kind[a] = (sel >= 8) ? PT_ANY : PT_INSIDE;
        if (sel == 7) begin
          // break a single axis at one of its borders
          kind[$urandom_range(0, 2)] = $urandom_range(0, 1) ? PT_EDGE_HIGH : PT_EDGE_LOW;
        end
        p.x    = axis_coord(0, kind[0]);
        p.y    = axis_coord(1, kind[1]);
        p.z    = axis_coord(2, kind[2]);
        p.last = ($urandom_range(0, 15) == 0);
        send_point(p);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin : run
    for (int a = 0; a < 3; a++) begin
      grid_origin[a] = '0;
      voxel_step[a]  = (CB-1)'(STEP_RESET);
    end
    grid_dims = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed part under light idling on both sides
    gap_max = 3;
    rx_mode = RX_RANDOM;
    test_reset_state();
    test_unit_grid();
    test_extremes();
    test_special_cases();

    test_random_phases(10, 93);

    drain();
    // idle past the pipeline depth so a stray late transaction gets caught
    repeat (4 * (GB + 3)) @(posedge clk);

    $display("Sent %0d points through %0d register settings (%0d register writes),",
             n_points, n_settings, n_reg_writes);
    $display("checked %0d voxel results, %0d mismatches.", n_results, n_mismatch);
    if (n_mismatch == 0 && pending_voxels.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### filelist.f
rtl/p2v_pkg.sv
rtl/p2v_axis_div.sv
rtl/point_to_voxel_coordinate.sv
tb/tb_top.sv
